// File: design/pfla_pkg.sv
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared types and codes for the page free list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

  localparam int PAGE_W  = 10;
  localparam int COUNT_W = 11;
  localparam int STAT_W  = 2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic              func;
    logic [PAGE_W-1:0] page_id;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  result_page;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] pages_in_use_count;
  } rsp_t;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_FREE_ZERO
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [PAGE_W-1:0] page;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_POP
  } back_state_t;

endpackage

// File: design/pfla_front.sv
// ----------------------------------------------------------------------------
// pfla_front
// Request stage: takes a request beat, decodes it into a command.
// ----------------------------------------------------------------------------
module pfla_front
  import pfla_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic q_push,
  output cmd_t q_cmd,
  input  logic q_full
);

  logic f_valid;
  cmd_t f_cmd;
  cmd_t dec_cmd;
  logic take;

  always_comb begin
    dec_cmd.page = req.page_id;
    if (req.func == FUNC_FREE) begin
      dec_cmd.kind = (req.page_id == '0) ? CMD_FREE_ZERO : CMD_FREE;
    end else begin
      dec_cmd.kind = CMD_ALLOC;
    end
  end

  assign req_stall = f_valid && q_full;
  assign q_push    = f_valid && !q_full;
  assign q_cmd     = f_cmd;
  assign take      = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_cmd <= dec_cmd;
    end
  end

endmodule

// File: design/pfla_queue.sv
// ----------------------------------------------------------------------------
// pfla_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module pfla_queue
  import pfla_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: design/pfla_back.sv
// ----------------------------------------------------------------------------
// pfla_back
// Execution part: free list head, page count, link store, response register.
// ----------------------------------------------------------------------------
module pfla_back
  import pfla_pkg::*;
#(
  parameter int MAX_PAGES = 1024
)
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int DEPTH = (MAX_PAGES < (1 << PAGE_W)) ? MAX_PAGES : (1 << PAGE_W);
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_PAGES + 1);

  back_state_t   state;
  back_state_t   state_next;
  logic [PW-1:0] free_head;
  logic [PW-1:0] free_head_next;
  logic [CW-1:0] page_count;
  logic [CW-1:0] page_count_next;
  logic [PW-1:0] link_mem [DEPTH];
  logic [PW-1:0] rd_data;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  rsp_t          res;
  logic          load;
  logic          slot_free;
  logic [31:0]   cnt_w;
  logic [31:0]   cnt_inc_w;
  logic [31:0]   pid_w;

  assign cnt_w     = 32'(page_count);
  assign cnt_inc_w = cnt_w + 32'd1;
  assign pid_w     = 32'(q_cmd.page);
  assign slot_free = !rsp_valid || !rsp_stall;
  assign mem_waddr = q_cmd.page[PW-1:0];

  always_comb begin
    state_next      = state;
    free_head_next  = free_head;
    page_count_next = page_count;
    mem_we          = 1'b0;
    q_pop           = 1'b0;
    load            = 1'b0;
    res.result_page        = '0;
    res.status             = ST_OK;
    res.pages_in_use_count = cnt_w[COUNT_W-1:0];
    unique case (state)
      BK_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_ALLOC: begin
              if (free_head != '0) begin
                state_next = BK_POP;
              end else if (cnt_w < 32'(MAX_PAGES)) begin
                load                   = 1'b1;
                res.result_page        = cnt_w[PAGE_W-1:0];
                res.pages_in_use_count = cnt_inc_w[COUNT_W-1:0];
                page_count_next        = CW'(cnt_inc_w);
              end else begin
                load       = 1'b1;
                res.status = ST_EXHAUSTED;
              end
            end
            CMD_FREE: begin
              load = 1'b1;
              if (pid_w >= cnt_w) begin
                res.status = ST_IGNORED;
              end else begin
                mem_we         = 1'b1;
                free_head_next = q_cmd.page[PW-1:0];
              end
            end
            CMD_FREE_ZERO: begin
              load       = 1'b1;
              res.status = ST_IGNORED;
            end
            default: begin
              load       = 1'b1;
              res.status = ST_IGNORED;
            end
          endcase
        end
      end
      BK_POP: begin
        load            = 1'b1;
        res.result_page = PAGE_W'(free_head);
        free_head_next  = rd_data;
        state_next      = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      free_head  <= '0;
      page_count <= CW'(1);
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      free_head  <= free_head_next;
      page_count <= page_count_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= free_head;
    end
    rd_data <= link_mem[free_head];
  end

endmodule

// File: design/page_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// page_free_list_allocator_top
// Page allocator: linked free list with bump allocation of fresh pages.
// ----------------------------------------------------------------------------
// Each request beat gives exactly one response beat, in order. A free and an
// allocate served by a fresh page are done in the execution stage's idle
// state; an allocate served from the free list also passes the pop state,
// since the head's link comes from the link store through a registered read.
// A request crosses a decode register and a two-entry queue before the
// execution stage loads its response into the response register. Page 0 is
// reserved; freeing page 0 or a page not yet handed out returns status
// ignored, and allocating with no page left returns status exhausted and
// page 0.
module page_free_list_allocator_top
  import pfla_pkg::*;
#(
  parameter int MAX_PAGES = 1024
)
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic q_push;
  cmd_t q_in;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  pfla_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_push    (q_push),
    .q_cmd     (q_in),
    .q_full    (q_full)
  );

  pfla_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  pfla_back #(
    .MAX_PAGES (MAX_PAGES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_head),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the page free list allocator against a cycle-free predictor of its
// free list, bump count and link store. Request and response beats are driven
// with random gaps and stalls. The stimulus opens with edge cases, then runs
// random mixes that fill the page space to exhaustion, free and reallocate some
// of it, and end with a mix that includes stray and double frees.
// ----------------------------------------------------------------------------
module testbench;
  import pfla_pkg::*;

  localparam int PAGE_SPACE  = 1024;
  localparam int ITEM_TARGET = 1575;
  localparam int CYCLE_LIMIT = 600000;

  typedef enum int {
    MIX_OPEN,
    MIX_FILL,
    MIX_DRAIN,
    MIX_LOOSE
  } mix_t;

  class alloc_scoreboard;
    logic [PAGE_W-1:0]  head;
    logic [COUNT_W-1:0] page_total;
    logic [PAGE_W-1:0]  next_of [PAGE_SPACE];
    logic [PAGE_W-1:0]  held [$];
    rsp_t               pending [$];
    int                 mismatches;

    function new();
      head = '0;
      page_total = 11'd1;
      foreach (next_of[i]) next_of[i] = '0;
      mismatches = 0;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      e = '0;
      e.status = ST_OK;
      if (r.func == FUNC_ALLOC) begin
        if (head != '0) begin
          e.result_page = head;
          head = next_of[head];
        end else if (page_total < PAGE_SPACE) begin
          e.result_page = page_total[PAGE_W-1:0];
          page_total = page_total + 11'd1;
        end else begin
          e.status = ST_EXHAUSTED;
        end
        if (e.status == ST_OK) held.push_back(e.result_page);
      end else if (r.page_id == '0 || r.page_id >= page_total) begin
        e.status = ST_IGNORED;
      end else begin
        next_of[r.page_id] = head;
        head = r.page_id;
        for (int i = 0; i < held.size(); i++) begin
          if (held[i] == r.page_id) begin
            held.delete(i);
            break;
          end
        end
      end
      e.pages_in_use_count = page_total;
      pending.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response beat: page %0d status %0d count %0d",
                   got.result_page, got.status, got.pages_in_use_count);
        return;
      end
      e = pending.pop_front();
      if (got.result_page !== e.result_page || got.status !== e.status ||
          got.pages_in_use_count !== e.pages_in_use_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp page %0d status %0d count %0d, got page %0d status %0d count %0d",
                   e.result_page, e.status, e.pages_in_use_count,
                   got.result_page, got.status, got.pages_in_use_count);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  alloc_scoreboard sb = new();
  int  sent = 0;
  int  stall_left = 0;
  int  cycle_count = 0;
  bit  send_quiet = 1'b0;
  bit  recv_quiet = 1'b0;

  page_free_list_allocator_top #(.MAX_PAGES(PAGE_SPACE)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap(bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t alloc_req();
    req_t r;
    r.func = FUNC_ALLOC;
    r.page_id = PAGE_W'($urandom);
    return r;
  endfunction

  function automatic req_t free_req(int page);
    req_t r;
    r.func = FUNC_FREE;
    r.page_id = PAGE_W'(page);
    return r;
  endfunction

  // page 0 or a page never handed out
  function automatic req_t bad_free_req();
    if (sb.page_total >= PAGE_SPACE || $urandom_range(0, 1) == 0) return free_req(0);
    return free_req($urandom_range(int'(sb.page_total), PAGE_SPACE - 1));
  endfunction

  function automatic req_t next_item(mix_t mix);
    int roll;
    int alloc_pct;
    int held_pct;
    int bad_pct;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_OPEN: begin
        alloc_pct = 50; held_pct = 40; bad_pct = 10;
      end
      MIX_FILL: begin
        alloc_pct = 92; held_pct = 5; bad_pct = 3;
      end
      MIX_DRAIN: begin
        alloc_pct = 70; held_pct = 30; bad_pct = 0;
      end
      default: begin
        alloc_pct = 45; held_pct = 35; bad_pct = 10;
      end
    endcase
    if (roll < alloc_pct) return alloc_req();
    if (roll < alloc_pct + held_pct) begin
      if (sb.held.size() == 0) return alloc_req();
      return free_req(sb.held[$urandom_range(0, sb.held.size() - 1)]);
    end
    if (roll < alloc_pct + held_pct + bad_pct) return bad_free_req();
    // stray free: may hit a page already on the list
    return free_req($urandom_range(1, PAGE_SPACE - 1));
  endfunction

  task automatic send_req(input req_t item);
    int gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(item);
    sent++;
    if ($urandom_range(0, 119) == 0) send_quiet = !send_quiet;
    if ($urandom_range(0, 119) == 0) recv_quiet = !recv_quiet;
    @(negedge clk);
  endtask

  task automatic drain_wait();
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    int n;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else begin
      n = pick_gap(recv_quiet);
      rsp_stall <= (n > 0);
      if (n > 0) stall_left = n - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    req_t opening [$];
    int failures;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    opening = '{
      free_req(0), free_req(1), free_req(PAGE_SPACE - 1),
      free_req(1023), '{FUNC_ALLOC, 10'h3FF}, '{FUNC_ALLOC, 10'h000},
      alloc_req(), alloc_req(),
      free_req(2), free_req(4), free_req(5),
      alloc_req(), alloc_req(), alloc_req(),
      free_req(1), free_req(3), free_req(5), free_req(0),
      alloc_req(), alloc_req(), alloc_req(), alloc_req()
    };
    foreach (opening[i]) send_req(opening[i]);
    drain_wait();

    repeat (300) send_req(next_item(MIX_OPEN));
    while (!(sb.page_total == PAGE_SPACE && sb.head == '0))
      send_req(next_item(MIX_FILL));
    repeat (15) send_req(alloc_req());
    drain_wait();

    repeat (40) send_req(next_item(MIX_DRAIN));
    while (sent < ITEM_TARGET) send_req(next_item(MIX_LOOSE));

    drain_wait();
    repeat (20) @(posedge clk);
    failures = sb.mismatches + sb.pending.size();
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
